FILE: src/ucrb_pkg.sv
// Shared types, codes and constants for the console UART ring buffers.
// No dependencies; every other file of the block imports this package.
package ucrb_pkg;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int TXL_W  = 9;
    localparam int RXL_W  = 6;

    // operation codes of an input item
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_TXRDY  = 2'd1;
    localparam logic [OP_W-1:0] OP_RXBYTE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] K_UART    = 2'd0;
    localparam logic [KIND_W-1:0] K_HANDLER = 2'd1;
    localparam logic [KIND_W-1:0] K_READ    = 2'd2;
    localparam logic [KIND_W-1:0] K_STATUS  = 2'd3;

    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h7F;

    // configuration port
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COOKED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_EN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIFO    = 3'd4;
    localparam logic [CFG_W-1:0]     FIFO_DEPTH_RST = 5'd16;

    // default sizes
    localparam int TX_DEPTH_DEF = 256;
    localparam int RX_DEPTH_DEF = 32;
    localparam int FIFO_MAX_DEF = 16;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    typedef struct packed {
        logic              cooked;
        logic              sync;
        logic              ring_en;
        logic              handler_on;
        logic [CFG_W-1:0]  fifo_depth;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data_byte;
        logic              uart_idle;
        logic              uart_byte_valid;
        logic              direct;      // host bytes bypass the transmit ring
        logic              handler;     // received byte goes to the handler
        logic              need_cr;     // carriage return goes out first
        logic [BYTE_W-1:0] first_byte;  // first host byte to handle
    } t_cmd;

endpackage

FILE: src/ucrb_in_if.sv
// Input item channel: valid/ready handshake with the item fields.
// Depends on ucrb_pkg.
interface ucrb_in_if;
    import ucrb_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data_byte;
    logic              uart_idle;
    logic              uart_byte_valid;

    modport source (output valid, output op, output data_byte, output uart_idle,
                    output uart_byte_valid, input ready);
    modport sink   (input valid, input op, input data_byte, input uart_idle,
                    input uart_byte_valid, output ready);
endinterface

FILE: src/ucrb_out_if.sv
// Result channel: valid/ready handshake with the result fields.
// Depends on ucrb_pkg.
interface ucrb_out_if;
    import ucrb_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] out_byte;
    logic              read_valid;
    logic              rx_dropped;
    logic              room_to_write;
    logic [TXL_W-1:0]  tx_level;
    logic [RXL_W-1:0]  rx_level;
    logic              last;

    modport source (output valid, output kind, output out_byte, output read_valid,
                    output rx_dropped, output room_to_write, output tx_level,
                    output rx_level, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input read_valid,
                    input rx_dropped, input room_to_write, input tx_level,
                    input rx_level, input last, output ready);
endinterface

FILE: src/ucrb_front.sv
// Front end: takes input items and classifies them into queue commands.
// Depends on ucrb_pkg and ucrb_in_if.
module ucrb_front (
    ucrb_in_if.sink          i_in,
    input  ucrb_pkg::t_cfg   i_cfg,
    input  logic             i_q_full,
    output logic             o_push,
    output ucrb_pkg::t_cmd   o_cmd
);
    import ucrb_pkg::*;

    logic w_cr;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    // cooked line feed: carriage return goes first
    assign w_cr = (i_in.op == OP_WRITE) && i_cfg.cooked && (i_in.data_byte == CH_LF);

    always_comb begin
        o_cmd.op              = i_in.op;
        o_cmd.data_byte       = i_in.data_byte;
        o_cmd.uart_idle       = i_in.uart_idle;
        o_cmd.uart_byte_valid = i_in.uart_byte_valid;
        o_cmd.direct          = !i_cfg.ring_en || i_cfg.sync;
        o_cmd.handler         = i_cfg.handler_on;
        o_cmd.need_cr         = w_cr;
        o_cmd.first_byte      = w_cr ? CH_CR : i_in.data_byte;
    end
endmodule

FILE: src/ucrb_cmdq.sv
// Short command queue that decouples the front end from the back end.
// Depends on ucrb_pkg.
module ucrb_cmdq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ucrb_pkg::t_cmd   i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output ucrb_pkg::t_cmd   o_data
);
    import ucrb_pkg::*;

    localparam int QAW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int QCW = $clog2(CMDQ_DEPTH + 1);

    t_cmd           r_mem [CMDQ_DEPTH];
    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [QCW-1:0] r_cnt, n_cnt;
    logic           w_do_push, w_do_pop;

    assign o_full    = (r_cnt == QCW'(CMDQ_DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wr = (r_wr == QAW'(CMDQ_DEPTH - 1)) ? '0 : r_wr + QAW'(1);
        end
        if (w_do_pop) begin
            n_rd = (r_rd == QAW'(CMDQ_DEPTH - 1)) ? '0 : r_rd + QAW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + QCW'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

FILE: src/ucrb_back.sv
// Back end: sequencer that runs queued commands against the transmit and
// receive rings and emits results one at a time. Depends on ucrb_pkg, ucrb_out_if.
module ucrb_back #(
    parameter int TX_DEPTH = ucrb_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = ucrb_pkg::RX_DEPTH_DEF,
    parameter int FIFO_MAX = ucrb_pkg::FIFO_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ucrb_pkg::t_cfg   i_cfg,
    input  logic             i_cmd_valid,
    input  ucrb_pkg::t_cmd   i_cmd,
    output logic             o_cmd_pop,
    ucrb_out_if.source       o_out
);
    import ucrb_pkg::*;

    localparam int TPW = $clog2(2 * TX_DEPTH);
    localparam int TAW = $clog2(TX_DEPTH);
    localparam int TLW = $clog2(TX_DEPTH + 1);
    localparam int RPW = $clog2(2 * RX_DEPTH);
    localparam int RAW = $clog2(RX_DEPTH);
    localparam int RLW = $clog2(RX_DEPTH + 1);
    localparam int BURST_CAP = (FIFO_MAX < TX_DEPTH) ? FIFO_MAX : TX_DEPTH;
    localparam int CW = $clog2(BURST_CAP + 1);
    localparam int ROOM_LVL = TX_DEPTH - TX_DEPTH / 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_HBYTE = 3'd2;
    localparam logic [2:0] S_BREAD = 3'd3;
    localparam logic [2:0] S_BEMIT = 3'd4;
    localparam logic [2:0] S_HPUSH = 3'd5;
    localparam logic [2:0] S_STAT  = 3'd6;

    // ring memories
    logic [BYTE_W-1:0] r_tx_mem [TX_DEPTH];
    logic [BYTE_W-1:0] r_rx_mem [RX_DEPTH];
    logic [BYTE_W-1:0] r_tx_q, r_rx_q;

    // sequencer state
    logic [2:0]        r_state, n_state;
    t_cmd              r_cmd;
    logic [BYTE_W-1:0] r_cur, n_cur;
    logic              r_cr, n_cr;
    logic              r_idle, n_idle;
    logic              r_drop, n_drop;
    logic              r_bfull, n_bfull;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [TPW-1:0]    r_txw, n_txw, r_txr, n_txr;
    logic [RPW-1:0]    r_rxw, n_rxw, r_rxr, n_rxr;

    // output register
    logic              r_ov;
    logic [KIND_W-1:0] r_okind;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_orv, r_odrop, r_oroom, r_olast;
    logic [TXL_W-1:0]  r_otxl;
    logic [RXL_W-1:0]  r_orxl;

    logic              w_ofree, w_emit, w_erv, w_edrop, w_eroom, w_elast, w_hdone;
    logic [KIND_W-1:0] w_ekind;
    logic [BYTE_W-1:0] w_ebyte;
    logic [TXL_W-1:0]  w_etxl;
    logic [RXL_W-1:0]  w_erxl;
    logic              w_tx_we, w_rx_we;
    logic [TAW-1:0]    w_txw_idx, w_txr_idx;
    logic [RAW-1:0]    w_rxw_idx, w_rxr_idx;
    logic [TPW-1:0]    w_txw_inc, w_txr_inc;
    logic [RPW-1:0]    w_rxw_inc, w_rxr_inc;
    logic [TPW:0]      w_tx_diff;
    logic [RPW:0]      w_rx_diff;
    logic [TLW-1:0]    w_tx_lvl;
    logic [RLW-1:0]    w_rx_lvl;
    logic              w_tx_full, w_tx_empty, w_rx_full, w_rx_empty;
    logic [CW-1:0]     w_burst;

    // pointers count modulo twice the ring depth
    assign w_txw_idx = TAW'((r_txw >= TPW'(TX_DEPTH)) ? r_txw - TPW'(TX_DEPTH) : r_txw);
    assign w_txr_idx = TAW'((r_txr >= TPW'(TX_DEPTH)) ? r_txr - TPW'(TX_DEPTH) : r_txr);
    assign w_rxw_idx = RAW'((r_rxw >= RPW'(RX_DEPTH)) ? r_rxw - RPW'(RX_DEPTH) : r_rxw);
    assign w_rxr_idx = RAW'((r_rxr >= RPW'(RX_DEPTH)) ? r_rxr - RPW'(RX_DEPTH) : r_rxr);
    assign w_txw_inc = (r_txw == TPW'(2 * TX_DEPTH - 1)) ? '0 : r_txw + TPW'(1);
    assign w_txr_inc = (r_txr == TPW'(2 * TX_DEPTH - 1)) ? '0 : r_txr + TPW'(1);
    assign w_rxw_inc = (r_rxw == RPW'(2 * RX_DEPTH - 1)) ? '0 : r_rxw + RPW'(1);
    assign w_rxr_inc = (r_rxr == RPW'(2 * RX_DEPTH - 1)) ? '0 : r_rxr + RPW'(1);

    assign w_tx_diff = (r_txw >= r_txr) ? {1'b0, r_txw} - {1'b0, r_txr}
                     : {1'b0, r_txw} + (TPW+1)'(2 * TX_DEPTH) - {1'b0, r_txr};
    assign w_rx_diff = (r_rxw >= r_rxr) ? {1'b0, r_rxw} - {1'b0, r_rxr}
                     : {1'b0, r_rxw} + (RPW+1)'(2 * RX_DEPTH) - {1'b0, r_rxr};
    assign w_tx_lvl   = w_tx_diff[TLW-1:0];
    assign w_rx_lvl   = w_rx_diff[RLW-1:0];
    assign w_tx_full  = (w_tx_lvl == TLW'(TX_DEPTH));
    assign w_tx_empty = (r_txw == r_txr);
    assign w_rx_full  = (w_rx_lvl == RLW'(RX_DEPTH));
    assign w_rx_empty = (r_rxw == r_rxr);

    // burst size: zero acts as one, capped by the build limits
    always_comb begin
        if (i_cfg.fifo_depth == '0) begin
            w_burst = CW'(1);
        end else if (int'(i_cfg.fifo_depth) > BURST_CAP) begin
            w_burst = CW'(BURST_CAP);
        end else begin
            w_burst = CW'(i_cfg.fifo_depth);
        end
    end

    assign w_ofree = !r_ov || o_out.ready;

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_cr      = r_cr;
        n_idle    = r_idle;
        n_drop    = r_drop;
        n_bfull   = r_bfull;
        n_cnt     = r_cnt;
        n_txw     = r_txw;
        n_txr     = r_txr;
        n_rxw     = r_rxw;
        n_rxr     = r_rxr;
        o_cmd_pop = 1'b0;
        w_emit    = 1'b0;
        w_ekind   = K_STATUS;
        w_ebyte   = '0;
        w_erv     = 1'b0;
        w_edrop   = 1'b0;
        w_eroom   = 1'b0;
        w_etxl    = '0;
        w_erxl    = '0;
        w_elast   = 1'b0;
        w_tx_we   = 1'b0;
        w_rx_we   = 1'b0;
        w_hdone   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cur     = i_cmd.first_byte;
                    n_cr      = i_cmd.need_cr;
                    n_idle    = i_cmd.uart_idle;
                    n_drop    = 1'b0;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (r_cmd.op)
                    OP_WRITE: begin
                        n_state = S_HBYTE;
                    end
                    OP_TXRDY: begin
                        n_cnt   = '0;
                        n_bfull = 1'b0;
                        n_state = r_idle ? S_BREAD : S_STAT;
                    end
                    OP_RXBYTE: begin
                        if (r_cmd.handler) begin
                            if (w_ofree) begin
                                w_emit  = 1'b1;
                                w_ekind = K_HANDLER;
                                w_ebyte = r_cmd.data_byte & ASCII_MASK;
                                n_state = S_STAT;
                            end
                        end else if (!w_rx_full) begin
                            w_rx_we = 1'b1;
                            n_rxw   = w_rxw_inc;
                            n_state = S_STAT;
                        end else begin
                            n_drop  = 1'b1;
                            n_state = S_STAT;
                        end
                    end
                    default: begin
                        // host read
                        if (w_ofree) begin
                            w_emit  = 1'b1;
                            w_ekind = K_READ;
                            if (!w_rx_empty) begin
                                w_ebyte = r_rx_q & ASCII_MASK;
                                w_erv   = 1'b1;
                                n_rxr   = w_rxr_inc;
                            end else if (r_cmd.uart_byte_valid) begin
                                w_ebyte = r_cmd.data_byte & ASCII_MASK;
                                w_erv   = 1'b1;
                            end
                            n_state = S_STAT;
                        end
                    end
                endcase
            end
            S_HBYTE: begin
                if (r_cmd.direct) begin
                    if (w_ofree) begin
                        w_emit  = 1'b1;
                        w_ekind = K_UART;
                        w_ebyte = r_cur;
                        n_idle  = 1'b0;
                        w_hdone = 1'b1;
                    end
                end else if (w_tx_full) begin
                    n_cnt   = '0;
                    n_bfull = 1'b1;
                    n_state = S_BREAD;
                end else if (w_tx_empty && r_idle) begin
                    if (w_ofree) begin
                        w_emit  = 1'b1;
                        w_ekind = K_UART;
                        w_ebyte = r_cur;
                        n_idle  = 1'b0;
                        w_hdone = 1'b1;
                    end
                end else begin
                    w_tx_we = 1'b1;
                    n_txw   = w_txw_inc;
                    w_hdone = 1'b1;
                end
            end
            S_BREAD: begin
                // read pointer is stable this cycle, so r_tx_q is fresh next cycle
                if ((r_cnt == w_burst) || w_tx_empty) begin
                    n_state = r_bfull ? S_HPUSH : S_STAT;
                end else begin
                    n_state = S_BEMIT;
                end
            end
            S_BEMIT: begin
                if (w_ofree) begin
                    w_emit  = 1'b1;
                    w_ekind = K_UART;
                    w_ebyte = r_tx_q;
                    n_txr   = w_txr_inc;
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_BREAD;
                end
            end
            S_HPUSH: begin
                w_tx_we = 1'b1;
                n_txw   = w_txw_inc;
                n_idle  = 1'b0;
                w_hdone = 1'b1;
            end
            S_STAT: begin
                if (w_ofree) begin
                    w_emit  = 1'b1;
                    w_ekind = K_STATUS;
                    w_edrop = r_drop;
                    w_eroom = (w_tx_lvl <= TLW'(ROOM_LVL));
                    w_etxl  = TXL_W'(w_tx_lvl);
                    w_erxl  = RXL_W'(w_rx_lvl);
                    w_elast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // after a host byte: move on to the line feed, or finish with status
        if (w_hdone) begin
            if (r_cr) begin
                n_cur   = r_cmd.data_byte;
                n_cr    = 1'b0;
                n_state = S_HBYTE;
            end else begin
                n_state = S_STAT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_txw   <= '0;
            r_txr   <= '0;
            r_rxw   <= '0;
            r_rxr   <= '0;
            r_cnt   <= '0;
            r_bfull <= 1'b0;
            r_drop  <= 1'b0;
            r_cr    <= 1'b0;
            r_idle  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_txw   <= n_txw;
            r_txr   <= n_txr;
            r_rxw   <= n_rxw;
            r_rxr   <= n_rxr;
            r_cnt   <= n_cnt;
            r_bfull <= n_bfull;
            r_drop  <= n_drop;
            r_cr    <= n_cr;
            r_idle  <= n_idle;
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (w_emit) begin
            r_okind <= w_ekind;
            r_obyte <= w_ebyte;
            r_orv   <= w_erv;
            r_odrop <= w_edrop;
            r_oroom <= w_eroom;
            r_otxl  <= w_etxl;
            r_orxl  <= w_erxl;
            r_olast <= w_elast;
        end
    end

    // ring memories with registered read at the current read pointer
    always_ff @(posedge i_clk) begin
        if (w_tx_we) begin
            r_tx_mem[w_txw_idx] <= r_cur;
        end
        r_tx_q <= r_tx_mem[w_txr_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_rx_we) begin
            r_rx_mem[w_rxw_idx] <= r_cmd.data_byte;
        end
        r_rx_q <= r_rx_mem[w_rxr_idx];
    end

    assign o_out.valid         = r_ov;
    assign o_out.kind          = r_okind;
    assign o_out.out_byte      = r_obyte;
    assign o_out.read_valid    = r_orv;
    assign o_out.rx_dropped    = r_odrop;
    assign o_out.room_to_write = r_oroom;
    assign o_out.tx_level      = r_otxl;
    assign o_out.rx_level      = r_orxl;
    assign o_out.last          = r_olast;

`ifndef SYNTHESIS
    a_tx_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tx_lvl <= TLW'(TX_DEPTH))
        else $error("transmit ring level above its depth");

    a_rx_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rx_lvl <= RLW'(RX_DEPTH))
        else $error("receive ring level above its depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BEMIT) |-> !w_tx_empty)
        else $error("burst pop from an empty transmit ring");

    a_status_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STAT && w_ofree) |=> (r_state == S_IDLE && o_out.valid && o_out.last))
        else $error("status result did not close the item");
`endif
endmodule

FILE: src/uart_console_ring_buffers.sv
// Top level of the console UART ring buffers: configuration registers, front
// end, command queue and back-end sequencer. Depends on ucrb_pkg and the channel interfaces.
//
// The block keeps a transmit ring between a console host and a UART, and a
// receive ring the other way. Each input item is one of: host write, transmit
// ready event, UART byte received, host read. Every item produces zero or more
// byte results (to UART, to handler, or read data) and always ends with one
// status result marked last, carrying the ring levels, the dropped-byte flag
// and whether half the transmit ring is free. Items are accepted into a
// two-entry command queue, so while the queue has room the input side keeps
// transferring as the back end works on an earlier item and as a finished
// result waits in the output register. The back end runs one item at a time
// and emits one result per transfer: a simple item steps through pop from the
// queue, dispatch, one step per host byte and the status step (a received byte
// or a read finishes its work in dispatch, a cooked line feed adds a step for
// the carriage return); each byte drained from the transmit ring takes a read
// step and an emit step because the ring memory has a registered read port
// and the read pointer must settle before each pop. No clearing pass runs
// after reset: ring entries are read only after being written. Configuration
// registers take a write on any cycle with i_cfg_we high; write them only
// while the block has no item in flight. A write to an index beyond the
// register list is ignored.
module uart_console_ring_buffers #(
    parameter int TX_DEPTH = ucrb_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = ucrb_pkg::RX_DEPTH_DEF,
    parameter int FIFO_MAX = ucrb_pkg::FIFO_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ucrb_in_if.sink                        i_in,
    ucrb_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [ucrb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ucrb_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import ucrb_pkg::*;

    t_cfg r_cfg, n_cfg;
    t_cmd w_front_cmd, w_q_cmd;
    logic w_push, w_q_full, w_q_valid, w_q_pop;

    // Register file: hold each field until its index is written.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COOKED:  n_cfg.cooked     = i_cfg_wdata[0];
                CFG_SYNC:    n_cfg.sync       = i_cfg_wdata[0];
                CFG_RING_EN: n_cfg.ring_en    = i_cfg_wdata[0];
                CFG_HANDLER: n_cfg.handler_on = i_cfg_wdata[0];
                CFG_FIFO:    n_cfg.fifo_depth = i_cfg_wdata;
                default:     n_cfg = r_cfg;  // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cooked     <= 1'b0;
            r_cfg.sync       <= 1'b0;
            r_cfg.ring_en    <= 1'b1;
            r_cfg.handler_on <= 1'b0;
            r_cfg.fifo_depth <= FIFO_DEPTH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front end: classify each transferred item (direct path, handler, cooked CR).
    ucrb_front u_front (
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_front_cmd)
    );

    // Command queue: let the front keep accepting while the back end is busy.
    ucrb_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_cmd),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_cmd)
    );

    // Back end: run the rings and drive the result channel.
    ucrb_back #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH),
        .FIFO_MAX (FIFO_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_q_pop),
        .o_out       (o_out)
    );
endmodule
